@@ sv/cfd_pkg.sv @@
// cfd_pkg: shared types, constants and the crc-16 byte update for the frame deframer
// no dependencies; imported by the parser, emitter and top level
package cfd_pkg;

  // sync pattern and header geometry
  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;
  localparam int         HEAD_BYTES  = 10;

  // crc-16 modbus: reflected polynomial, all-ones start value
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // header bytes 2..7 as handed to the emitter
  typedef struct packed {
    logic [7:0] cfg;
    logic [7:0] seq;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] func;
    logic [7:0] cmd;
  } frame_hdr_t;

  // parser to emitter: start pulse for a checked frame plus its header
  typedef struct packed {
    logic       start;
    frame_hdr_t hdr;
  } emit_req_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/crc_checked_frame_deframer.sv @@
// crc_checked_frame_deframer: top level, sync/header/crc deframer with payload ram
// depends on cfd_pkg, cfd_parser, cfd_payload_ram, cfd_emitter
//
// Usage:
//   Input channel (rx_data, abort, in_valid/in_ready) takes one received byte per
//   beat. abort discards any partial frame and drops the byte. While no checked frame
//   is pending or being emitted, in_ready is high and a byte is taken every cycle.
//   A frame is sync 0xA5 0x5A, eight more header bytes (length little-endian in
//   header bytes 8 and 9), the payload, then a little-endian crc-16/modbus over
//   sync, header and payload. Frames with bad sync, oversize length or crc mismatch
//   produce nothing.
//   Output channel (frame_* fields, body_*, last, out_valid/out_ready) gives one
//   beat per payload byte, or one beat with index and byte zero for an empty
//   payload; last marks the final beat.
//   On a crc match the parser registers a start pulse; the emitter then reads the
//   payload ram and loads the output register (an empty payload skips the read);
//   each further byte is read from the ram only after the previous beat is taken.
//   From the cycle after the final crc byte until the last beat is taken, in_ready
//   is low; a stalled receiver holds the output register and the parser with it.
//   Reset (rst, synchronous) returns the parser to sync hunt and empties the
//   output; no clearing pass is needed.
module crc_checked_frame_deframer #(
  parameter int MAX_BODY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_data,
  input  logic       abort,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] frame_cfg,
  output logic [7:0] frame_seq,
  output logic [7:0] frame_src,
  output logic [7:0] frame_dst,
  output logic [7:0] frame_func,
  output logic [7:0] frame_cmd,
  output logic [6:0] body_length,
  output logic [5:0] body_index,
  output logic [7:0] body_byte,
  output logic       last,
  output logic       out_valid,
  input  logic       out_ready
);
  import cfd_pkg::*;

  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int LW = $clog2(MAX_BODY + 1);

  emit_req_t     req;
  logic [LW-1:0] body_len;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          busy;
  logic          accept;

  // input stalls while a checked frame is pending or draining
  assign in_ready = !(req.start || busy);
  assign accept   = in_valid && in_ready;

  cfd_parser #(.MAX_BODY(MAX_BODY)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_data  (rx_data),
    .abort    (abort),
    .req      (req),
    .body_len (body_len),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  cfd_payload_ram #(.MAX_BODY(MAX_BODY)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cfd_emitter #(.MAX_BODY(MAX_BODY)) u_emitter (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .body_len    (body_len),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_cfg   (frame_cfg),
    .frame_seq   (frame_seq),
    .frame_src   (frame_src),
    .frame_dst   (frame_dst),
    .frame_func  (frame_func),
    .frame_cmd   (frame_cmd),
    .body_length (body_length),
    .body_index  (body_index),
    .body_byte   (body_byte),
    .last        (last)
  );

`ifndef SYNTHESIS
  // ram writes and output beats never overlap
  a_no_write_while_emit: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && busy))
    else $error("payload write during emission");

  // a frame start only reaches an idle emitter
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("frame start while emitter busy");

  // after the final beat of a frame the output empties
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !out_valid)
    else $error("output still valid after last beat");

  // the input channel never accepts while a beat is shown
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during emission");
`endif

endmodule

@@ sv/cfd_payload_ram.sv @@
// cfd_payload_ram: payload byte store, one write port and one registered read port
// no package dependencies
module cfd_payload_ram #(
  parameter int MAX_BODY = 64,
  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [MAX_BODY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/cfd_parser.sv @@
// cfd_parser: sync hunt, header capture, payload write and crc check, one byte per beat
// depends on cfd_pkg; writes payload bytes into cfd_payload_ram
module cfd_parser #(
  parameter int MAX_BODY = 64,
  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1,
  localparam int LW = $clog2(MAX_BODY + 1),
  localparam int BW = $clog2(MAX_BODY + 12)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_data,
  input  logic               abort,
  output cfd_pkg::emit_req_t req,
  output logic [LW-1:0]      body_len,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data
);
  import cfd_pkg::*;

  typedef enum logic [4:0] {
    P_SYNC1 = 5'b00001,
    P_SYNC2 = 5'b00010,
    P_HEAD  = 5'b00100,
    P_BODY  = 5'b01000,
    P_CRC   = 5'b10000
  } phase_t;

  phase_t        phase, phase_next;
  logic [BW-1:0] count, count_next;
  logic [LW-1:0] exp_len, exp_len_next;
  logic [15:0]   crc, crc_next;
  logic [7:0]    crc_low, crc_low_next;
  logic          start, start_next;
  logic [7:0]    hdr [8];
  logic          hdr_we;

  logic [15:0]   crc_step;
  logic [15:0]   crc_first;
  logic [BW-1:0] pos;
  logic [2:0]    hdr_idx;
  logic [15:0]   len16;

  // datapath helpers
  assign crc_step  = crc_feed(crc, rx_data);
  assign crc_first = crc_feed(CRC_INIT, rx_data);
  assign pos       = count - BW'(HEAD_BYTES);
  assign hdr_idx   = 3'(count - BW'(2));
  assign len16     = {rx_data, hdr[6]};

  // frame parse state update
  always_comb begin
    phase_next   = phase;
    count_next   = count;
    exp_len_next = exp_len;
    crc_next     = crc;
    crc_low_next = crc_low;
    start_next   = 1'b0;
    hdr_we       = 1'b0;
    wr_en        = 1'b0;
    if (accept) begin
      if (abort) begin
        phase_next = P_SYNC1;
        count_next = '0;
      end else begin
        unique case (phase)
          P_SYNC1: begin
            if (rx_data == SYNC_FIRST) begin
              crc_next   = crc_first;
              count_next = BW'(1);
              phase_next = P_SYNC2;
            end
          end
          P_SYNC2: begin
            if (rx_data == SYNC_SECOND) begin
              crc_next   = crc_step;
              count_next = BW'(2);
              phase_next = P_HEAD;
            end else begin
              phase_next = P_SYNC1;
              count_next = '0;
            end
          end
          P_HEAD: begin
            if (count < BW'(2) || count >= BW'(HEAD_BYTES)) begin
              phase_next = P_SYNC1;
              count_next = '0;
            end else begin
              hdr_we     = 1'b1;
              crc_next   = crc_step;
              count_next = count + BW'(1);
              // last header byte carries the length high byte
              if (count == BW'(HEAD_BYTES - 1)) begin
                if (len16 > 16'(MAX_BODY)) begin
                  phase_next = P_SYNC1;
                  count_next = '0;
                end else begin
                  exp_len_next = LW'(len16);
                  phase_next   = (len16 == 16'd0) ? P_CRC : P_BODY;
                end
              end
            end
          end
          P_BODY: begin
            if (count < BW'(HEAD_BYTES) || pos >= BW'(MAX_BODY)) begin
              phase_next = P_SYNC1;
              count_next = '0;
            end else begin
              wr_en      = 1'b1;
              crc_next   = crc_step;
              count_next = count + BW'(1);
              if (count + BW'(1) >= BW'(HEAD_BYTES) + BW'(exp_len)) begin
                phase_next = P_CRC;
              end
            end
          end
          P_CRC: begin
            if (count == BW'(HEAD_BYTES) + BW'(exp_len)) begin
              crc_low_next = rx_data;
              count_next   = count + BW'(1);
            end else begin
              // high crc byte: compare and release the frame on a match
              if ({rx_data, crc_low} == crc) begin
                start_next = 1'b1;
              end
              phase_next = P_SYNC1;
              count_next = '0;
            end
          end
          default: begin
            phase_next = P_SYNC1;
            count_next = '0;
          end
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= P_SYNC1;
      count   <= '0;
      exp_len <= '0;
      crc     <= CRC_INIT;
      start   <= 1'b0;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      exp_len <= exp_len_next;
      crc     <= crc_next;
      start   <= start_next;
    end
  end

  // header bytes and low crc byte
  always_ff @(posedge clk) begin
    crc_low <= crc_low_next;
    if (hdr_we) begin
      hdr[hdr_idx] <= rx_data;
    end
  end

  // payload write port
  assign wr_addr = pos[AW-1:0];
  assign wr_data = rx_data;

  // request to the emitter
  assign req.start    = start;
  assign req.hdr.cfg  = hdr[0];
  assign req.hdr.seq  = hdr[1];
  assign req.hdr.src  = hdr[2];
  assign req.hdr.dst  = hdr[3];
  assign req.hdr.func = hdr[4];
  assign req.hdr.cmd  = hdr[5];
  assign body_len     = exp_len;

endmodule

@@ sv/cfd_emitter.sv @@
// cfd_emitter: reads a checked frame back out of the payload ram into the output register
// depends on cfd_pkg; reads cfd_payload_ram
module cfd_emitter #(
  parameter int MAX_BODY = 64,
  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1,
  localparam int LW = $clog2(MAX_BODY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfd_pkg::emit_req_t req,
  input  logic [LW-1:0]      body_len,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [7:0]         rd_data,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         frame_cfg,
  output logic [7:0]         frame_seq,
  output logic [7:0]         frame_src,
  output logic [7:0]         frame_dst,
  output logic [7:0]         frame_func,
  output logic [7:0]         frame_cmd,
  output logic [6:0]         body_length,
  output logic [5:0]         body_index,
  output logic [7:0]         body_byte,
  output logic               last
);
  import cfd_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_FETCH = 3'b010,
    E_SHOW  = 3'b100
  } emit_state_t;

  emit_state_t   state, state_next;
  logic [LW-1:0] idx, idx_next;
  logic [LW-1:0] idx_inc;
  logic          load_fetch;
  logic          load_empty;

  assign idx_inc = idx + LW'(1);

  // read sequencing: one payload byte per beat
  always_comb begin
    state_next = state;
    idx_next   = idx;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load_fetch = 1'b0;
    load_empty = 1'b0;
    unique case (state)
      E_IDLE: begin
        if (req.start) begin
          idx_next = '0;
          if (body_len == '0) begin
            load_empty = 1'b1;
            state_next = E_SHOW;
          end else begin
            rd_en      = 1'b1;
            state_next = E_FETCH;
          end
        end
      end
      E_FETCH: begin
        load_fetch = 1'b1;
        state_next = E_SHOW;
      end
      E_SHOW: begin
        if (out_ready) begin
          if (last) begin
            state_next = E_IDLE;
          end else begin
            idx_next   = idx_inc;
            rd_en      = 1'b1;
            rd_addr    = idx_inc[AW-1:0];
            state_next = E_FETCH;
          end
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load_fetch || load_empty) begin
      frame_cfg   <= req.hdr.cfg;
      frame_seq   <= req.hdr.seq;
      frame_src   <= req.hdr.src;
      frame_dst   <= req.hdr.dst;
      frame_func  <= req.hdr.func;
      frame_cmd   <= req.hdr.cmd;
      body_length <= 7'(body_len);
    end
    if (load_empty) begin
      body_index <= '0;
      body_byte  <= '0;
      last       <= 1'b1;
    end else if (load_fetch) begin
      body_index <= 6'(idx);
      body_byte  <= rd_data;
      last       <= (idx_inc == body_len);
    end
  end

  assign out_valid = (state == E_SHOW);
  assign busy      = (state != E_IDLE);

endmodule
